// ===== sv/multi_lane_crc8_first_match_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-lane CRC-8 first-match checker
// Shared property forms used by the port-level checker. They expect clk and
// rst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef MULTI_LANE_CRC8_FIRST_MATCH_ASSERT_SVH
`define MULTI_LANE_CRC8_FIRST_MATCH_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define MLC8_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlc8 same-cycle property failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define MLC8_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlc8 next-cycle property failed");

`endif

// ===== sv/mlc8_pkg.sv =====
// ----------------------------------------------------------------------------
// mlc8_pkg
// Types, constants and the CRC-8 byte update shared by the lanes, the merge
// stage and the top level.
// ----------------------------------------------------------------------------
package mlc8_pkg;

  localparam int BYTE_W     = 8;
  localparam int BUS_W      = 64;
  localparam int LANE_IDX_W = 3;
  localparam int ACT_W      = 4;

  // CRC-8 with polynomial x^8+x^2+x+1, MSB first.
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  // Reset value of the active lane count.
  localparam logic [ACT_W-1:0] ACTIVE_RST = 4'd8;

  // Per-cycle command from the top level to every lane.
  typedef struct packed {
    logic load;   // fold the lane byte into the running CRC
    logic clear;  // check item taken: return the CRC to its initial value
  } lane_ctl_t;

  // One byte through the CRC, eight shift steps.
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/mlc8_in_if.sv =====
// ----------------------------------------------------------------------------
// mlc8_in_if
// Input channel: one byte column for all lanes plus the check-item mark.
// ----------------------------------------------------------------------------
interface mlc8_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] lane_bytes;
  logic        last_byte;

  modport source (output valid, output lane_bytes, output last_byte, input ready);
  modport sink   (input valid, input lane_bytes, input last_byte, output ready);
endinterface

// ===== sv/mlc8_out_if.sv =====
// ----------------------------------------------------------------------------
// mlc8_out_if
// Result channel: match flag and lowest matching lane.
// ----------------------------------------------------------------------------
interface mlc8_out_if;
  logic       valid;
  logic       ready;
  logic       match_found;
  logic [2:0] match_lane;

  modport source (output valid, output match_found, output match_lane, input ready);
  modport sink   (input valid, input match_found, input match_lane, output ready);
endinterface

// ===== sv/mlc8_lane.sv =====
// ----------------------------------------------------------------------------
// mlc8_lane
// One CRC-8 lane: keeps the running CRC of its byte stream and compares it
// with the byte presented on the current item.
// ----------------------------------------------------------------------------
module mlc8_lane
  import mlc8_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lane_ctl_t         ctl,
  input  logic [BYTE_W-1:0] lane_byte,
  output logic              match
);

  logic [BYTE_W-1:0] crc_r;
  logic [BYTE_W-1:0] crc_nxt;

  // Clear wins over load; the two are never raised together.
  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clear) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.load) begin
      crc_nxt = crc8_byte(crc_r, lane_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  // On a check item the lane byte is the appended check value.
  assign match = (crc_r == lane_byte);

endmodule

// ===== sv/mlc8_merge.sv =====
// ----------------------------------------------------------------------------
// mlc8_merge
// Masks the lane compares with the active lane count, picks the lowest
// matching lane and holds the result in the output register.
// ----------------------------------------------------------------------------
module mlc8_merge
  import mlc8_pkg::*;
#(
  parameter int LANES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [LANES-1:0]      lane_match,
  input  logic [ACT_W-1:0]      active_lanes,
  input  logic                  check_fire,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  match_found,
  output logic [LANE_IDX_W-1:0] match_lane
);

  logic                  valid_r;
  logic                  valid_nxt;
  logic                  found_r;
  logic [LANE_IDX_W-1:0] lane_r;
  logic                  found_nxt;
  logic [LANE_IDX_W-1:0] lane_nxt;

  // Lowest active matching lane: scan from the top so the lowest one wins.
  always_comb begin
    found_nxt = 1'b0;
    lane_nxt  = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (lane_match[k] && (ACT_W'(k) < active_lanes)) begin
        found_nxt = 1'b1;
        lane_nxt  = LANE_IDX_W'(k);
      end
    end
  end

  // The output register fills on a check item and empties when taken.
  always_comb begin
    valid_nxt = valid_r;
    if (check_fire) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (check_fire) begin
      found_r <= found_nxt;
      lane_r  <= lane_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign match_found = found_r;
  assign match_lane  = lane_r;

endmodule

// ===== sv/multi_lane_crc8_first_match.sv =====
// ----------------------------------------------------------------------------
// multi_lane_crc8_first_match
// Parallel CRC-8 check over up to eight candidate byte arrays with a
// lowest-matching-lane report.
// ----------------------------------------------------------------------------
// Each input item carries one byte per lane; LANES CRC-8 lanes (polynomial
// 0x07, initial value zero, MSB first, no final xor) fold their bytes in the
// same cycle, so the block takes one item per clock. An item with last_byte
// set carries each lane's check byte: the lane compares and the merge stage
// picks the lowest lane below active_lanes that matches, returning one result
// in the next cycle from the output register, and all lane CRCs return to zero.
// Data items are taken in every cycle regardless of the result channel; a
// check item waits only while the output register still holds a result that
// has not been taken, and that wait is set by the single output register.
// active_lanes may only be written while no item is in flight.
// ----------------------------------------------------------------------------
module multi_lane_crc8_first_match
  import mlc8_pkg::*;
#(
  parameter int LANES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [ACT_W-1:0] cfg_wdata,
  mlc8_in_if.sink          in_ch,
  mlc8_out_if.source       out_ch
);

  logic [ACT_W-1:0]      active_lanes_r;
  logic                  in_fire;
  logic                  check_fire;
  logic                  res_valid;
  logic                  res_found;
  logic [LANE_IDX_W-1:0] res_lane;
  logic [LANES-1:0]      lane_match;
  lane_ctl_t             lane_ctl;

  // Active lane count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_lanes_r <= ACTIVE_RST;
    end else if (cfg_we) begin
      active_lanes_r <= cfg_wdata;
    end
  end

  // Data items never wait; a check item needs room in the output register.
  assign in_ch.ready = !in_ch.last_byte || !res_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign check_fire  = in_fire && in_ch.last_byte;

  assign lane_ctl.load  = in_fire && !in_ch.last_byte;
  assign lane_ctl.clear = check_fire;

  // One CRC lane per candidate array.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mlc8_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (lane_ctl),
      .lane_byte (in_ch.lane_bytes[BYTE_W*g +: BYTE_W]),
      .match     (lane_match[g])
    );
  end

  // Lowest-match selection and output register.
  mlc8_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .lane_match   (lane_match),
    .active_lanes (active_lanes_r),
    .check_fire   (check_fire),
    .out_ready    (out_ch.ready),
    .out_valid    (res_valid),
    .match_found  (res_found),
    .match_lane   (res_lane)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.match_found = res_found;
  assign out_ch.match_lane  = res_lane;

endmodule

// ===== sv/mlc8_checker.sv =====
// ----------------------------------------------------------------------------
// mlc8_checker
// Port-level checks for the multi-lane CRC-8 first-match block, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "multi_lane_crc8_first_match_assert.svh"

module mlc8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_match_found,
  input logic [2:0] out_match_lane
);

  logic in_fire;

  assign in_fire = in_valid && in_ready;

  // A result that is not taken stays put.
  `MLC8_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_match_found) && $stable(out_match_lane))

  // A no-match result always reports lane zero.
  `MLC8_ASSERT_IMP(a_nomatch_lane, out_valid && !out_match_found, out_match_lane == 3'd0)

  // An accepted check item produces a result in the next cycle.
  `MLC8_ASSERT_NXT(a_check_result, in_fire && in_last_byte, out_valid)

  // A data item never creates a result.
  `MLC8_ASSERT_NXT(a_data_silent, !out_valid && !(in_fire && in_last_byte), !out_valid)

endmodule

bind multi_lane_crc8_first_match mlc8_checker u_mlc8_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_last_byte    (in_ch.last_byte),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_match_found (out_ch.match_found),
  .out_match_lane  (out_ch.match_lane)
);

// ===== sim/mlc8_match_checker.sv =====
// ----------------------------------------------------------------------------
// mlc8_match_checker
// Watches the input, result and configuration ports of the multi-lane CRC-8
// first-match block. It keeps its own per-lane CRC state and active lane
// count, works out the match report each check item should produce, and
// compares every result taken from the block against the oldest outstanding
// report, field by field.
// ----------------------------------------------------------------------------
module mlc8_match_checker
  import mlc8_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [ACT_W-1:0] cfg_wdata,
  mlc8_in_if               in_mon,
  mlc8_out_if              out_mon,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              LANE_COUNT = 8;
  localparam logic [7:0]      GEN_POLY   = 8'h07;

  typedef struct packed {
    logic       found;
    logic [2:0] lane;
  } match_t;

  logic [7:0]       lane_sum [LANE_COUNT];
  logic [ACT_W-1:0] lanes_in_use;
  match_t           due_reports [$];
  int               mismatch_total = 0;

  assign fail_count = mismatch_total;

  // Bitwise CRC-8 update of one byte, MSB first.
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[7] ? ((r << 1) ^ GEN_POLY) : (r << 1);
    return r;
  endfunction

  // Data items fold into every lane; a check item yields one report and
  // clears all lanes.
  task automatic absorb_column(input logic [63:0] bytes, input logic last);
    int unsigned span;
    match_t      want;
    span = (lanes_in_use > LANE_COUNT) ? LANE_COUNT : lanes_in_use;
    if (!last) begin
      for (int k = 0; k < LANE_COUNT; k++) begin
        lane_sum[k] = crc8_fold(lane_sum[k], bytes[8*k +: 8]);
      end
    end else begin
      want = '0;
      for (int k = 0; k < LANE_COUNT; k++) begin
        if (k < span && !want.found && lane_sum[k] == bytes[8*k +: 8]) begin
          want.found = 1'b1;
          want.lane  = k[2:0];
        end
      end
      due_reports.push_back(want);
      for (int k = 0; k < LANE_COUNT; k++) begin
        lane_sum[k] = 8'h00;
      end
    end
  endtask

  // Count a failure; only the first few are printed.
  task automatic report_mismatch(input string what, input match_t want, input match_t got);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("[%0t] %s: expected found=%0b lane=%0d, actual found=%0b lane=%0d",
               $time, what, want.found, want.lane, got.found, got.lane);
    end
  endtask

  // Results are compared before the item of the same edge is absorbed, so a
  // report can never be matched against a result of the same cycle.
  always @(posedge clk) begin : watch
    match_t got;
    match_t want;
    if (!rst_n) begin
      for (int k = 0; k < LANE_COUNT; k++) begin
        lane_sum[k] = 8'h00;
      end
      lanes_in_use = ACTIVE_RST;
      due_reports.delete();
    end else begin
      if (cfg_we) begin
        lanes_in_use = cfg_wdata;
      end
      if (out_mon.valid && out_mon.ready) begin
        got.found = out_mon.match_found;
        got.lane  = out_mon.match_lane;
        if (due_reports.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = due_reports.pop_front();
          if (got.found !== want.found || got.lane !== want.lane) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        absorb_column(in_mon.lane_bytes, in_mon.last_byte);
      end
    end
    pending <= due_reports.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multi-lane CRC-8 first-match block. A short
// directed run covers empty messages, all-zero and all-one columns, first
// match priority and the active lane count at zero, one and above eight;
// random phases then send messages with check bytes that are right on a
// random set of lanes, plus some unstructured noise, under random input
// gaps and result stalls. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlc8_pkg::*;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_we     = 1'b0;
  logic [ACT_W-1:0] cfg_wdata  = '0;
  logic             sink_ready = 1'b0;
  int               mismatches;
  int               in_flight;
  int unsigned      items_sent = 0;
  int unsigned      ready_hold = 0;
  int unsigned      free_run   = 0;
  logic [7:0]       sent_crc [8];

  mlc8_in_if  in_ch ();
  mlc8_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  multi_lane_crc8_first_match #(
    .LANES(8)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  mlc8_match_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(mismatches),
    .pending   (in_flight)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side stalls: mostly short, a few long, with stall-free stretches.
  always @(posedge clk) begin : drive_ready
    int unsigned r;
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (free_run != 0) begin
      free_run   <= free_run - 1;
      sink_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        sink_ready <= 1'b1;
      end else if (r < 85) begin
        sink_ready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else if (r < 95) begin
        sink_ready <= 1'b1;
        free_run   <= $urandom_range(20, 60);
      end else begin
        sink_ready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  // One byte column after an optional random gap; waits for the handshake.
  // Keeps a running CRC per lane so that check columns can be built.
  task automatic send_column(input logic [63:0] bytes, input logic last, input bit steady);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 2);
      else if (r < 95) gap = $urandom_range(3, 6);
      else gap = $urandom_range(10, 30);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.lane_bytes <= bytes;
    in_ch.last_byte  <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    for (int k = 0; k < 8; k++) begin
      sent_crc[k] = last ? 8'h00 : crc8_byte(sent_crc[k], bytes[8*k +: 8]);
    end
  endtask

  // Data column: mostly random, sometimes all zeros or all ones.
  function automatic logic [63:0] random_column();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return {$urandom, $urandom};
  endfunction

  // Check column: correct CRC on the lanes set in hit, a wrong byte elsewhere.
  function automatic logic [63:0] check_column(input logic [7:0] hit);
    logic [63:0] col;
    for (int k = 0; k < 8; k++) begin
      col[8*k +: 8] = hit[k] ? sent_crc[k] : sent_crc[k] ^ 8'($urandom_range(1, 255));
    end
    return col;
  endfunction

  // Well-formed message: data columns of random length, then a check column.
  task automatic send_message();
    int unsigned len;
    int unsigned r;
    bit          steady;
    logic [7:0]  hit;
    steady = ($urandom_range(0, 99) < 25);
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 85) len = $urandom_range(1, 6);
    else if (r < 97) len = $urandom_range(7, 20);
    else len = $urandom_range(21, 60);
    for (int i = 0; i < len; i++) begin
      send_column(random_column(), 1'b0, steady);
    end
    r = $urandom_range(0, 99);
    if (r < 15) hit = 8'h00;
    else if (r < 30) hit = 8'hFF;
    else if (r < 45) hit = 8'h01 << $urandom_range(0, 7);
    else hit = 8'($urandom & $urandom);
    send_column(check_column(hit), 1'b1, steady);
  endtask

  // Noise: random columns with the check mark set at random.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      send_column(random_column(), ($urandom_range(0, 3) == 0), 1'b0);
    end
  endtask

  // Write the lane count once nothing is outstanding and the block has settled.
  task automatic set_active_lanes(input logic [ACT_W-1:0] n);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned      phase_end;
    logic [ACT_W-1:0] lanes;
    in_ch.valid      <= 1'b0;
    in_ch.lane_bytes <= '0;
    in_ch.last_byte  <= 1'b0;
    for (int k = 0; k < 8; k++) begin
      sent_crc[k] = 8'h00;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty messages: zero check bytes match lane 0, all-ones match nothing.
    send_column('0, 1'b1, 1'b0);
    send_column('1, 1'b1, 1'b0);
    // Extreme columns, only the top lane right.
    send_column('1, 1'b0, 1'b0);
    send_column('0, 1'b0, 1'b0);
    send_column(check_column(8'h80), 1'b1, 1'b0);
    // Two lanes right: the lower one wins.
    send_column(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
    send_column(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    send_column(check_column(8'h28), 1'b1, 1'b0);
    // No lane right.
    send_column(random_column(), 1'b0, 1'b0);
    send_column(check_column(8'h00), 1'b1, 1'b0);
    // No active lanes: never a match.
    set_active_lanes(4'd0);
    send_column(random_column(), 1'b0, 1'b0);
    send_column(check_column(8'hFF), 1'b1, 1'b0);
    // Count above eight behaves as eight.
    set_active_lanes(4'd15);
    send_column(random_column(), 1'b0, 1'b0);
    send_column(check_column(8'h80), 1'b1, 1'b0);
    // One active lane: lane 1 is ignored, lane 0 still matches.
    set_active_lanes(4'd1);
    send_column(random_column(), 1'b0, 1'b0);
    send_column(check_column(8'h02), 1'b1, 1'b0);
    send_column(check_column(8'h01), 1'b1, 1'b0);

    // Random phases, each under its own lane count.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: lanes = 4'd1;
        1: lanes = 4'd8;
        2: lanes = 4'd0;
        3: lanes = 4'd15;
        default: lanes = 4'($urandom_range(0, 15));
      endcase
      set_active_lanes(lanes);
      phase_end = items_sent + 120;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_message();
      end
    end

    // Drain and give the verdict.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
